/* sv/rle8_pkg.sv */
// Shared types and constants for the 8-bit run-length bitmap decoder.
// No dependencies; all other files but rle8_palette refer to it by scoped names.
package rle8_pkg;

   // Input operation codes.
   localparam logic [1:0] OP_STREAM  = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_FRAME   = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_PIXELS = 2'd0;
   localparam logic [1:0] KIND_MOVE   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_X     = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Y     = 2'd2;

   localparam int FRAME_HEIGHT_RESET = 240;

   // One decoded result as it leaves the decoder, before the palette colour is known.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic [7:0]  run_count;
      logic        use_palette;
   } result_type;

endpackage

/* sv/rle8_palette.sv */
// Palette memory: one write port and one registered read port.
// Depends on nothing but its parameters.
module rle8_palette #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [15:0]              wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [15:0]              rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rle8_fsm.sv */
// Stream parser: phase, cursor and literal counters, and result formation.
// Depends on rle8_pkg for operation codes, result kinds and the result struct.
module rle8_fsm #(
   parameter int COORD_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           operation,
   input  logic [7:0]           stream_byte,
   input  logic [10:0]          frame_height,
   input  logic [9:0]           origin_x,
   input  logic [9:0]           origin_y,
   output rle8_pkg::result_type result
);

   localparam logic [2:0] PH_COUNT  = 3'd0;
   localparam logic [2:0] PH_ESC    = 3'd1;
   localparam logic [2:0] PH_COLOUR = 3'd2;
   localparam logic [2:0] PH_DX     = 3'd3;
   localparam logic [2:0] PH_DY     = 3'd4;
   localparam logic [2:0] PH_LIT    = 3'd5;
   localparam logic [2:0] PH_PAD    = 3'd6;
   localparam logic [2:0] PH_END    = 3'd7;

   localparam int FH_W  = (COORD_BITS > 11) ? COORD_BITS : 11;
   localparam int SUM_W = ((COORD_BITS > 10) ? COORD_BITS : 10) + 1;
   localparam logic [FH_W-1:0] RESET_Y = FH_W'(rle8_pkg::FRAME_HEIGHT_RESET - 1);

   logic [2:0]            phase_ff, phase_in;
   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [7:0]            pending_ff, pending_in;
   logic                  pad_ff, pad_in;

   logic [FH_W-1:0]       bottom_row;
   logic [7:0]            pending_dec;
   logic [COORD_BITS-1:0] sel_x, sel_y;
   logic [SUM_W-1:0]      sum_x, sum_y;

   assign bottom_row  = FH_W'(frame_height) - FH_W'(1);
   assign pending_dec = pending_ff - 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      pending_in  = pending_ff;
      pad_in      = pad_ff;
      result      = '0;

      if (accept && operation == rle8_pkg::OP_FRAME) begin
         phase_in    = PH_COUNT;
         cursor_x_in = '0;
         cursor_y_in = bottom_row[COORD_BITS-1:0];
         pending_in  = '0;
         pad_in      = 1'b0;
      end else if (accept && operation == rle8_pkg::OP_STREAM) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (stream_byte == 8'd0) begin
                  phase_in = PH_ESC;
               end else begin
                  pending_in = stream_byte;
                  phase_in   = PH_COLOUR;
               end
            end
            PH_COLOUR: begin
               result.valid       = 1'b1;
               result.kind        = rle8_pkg::KIND_PIXELS;
               result.run_count   = pending_ff;
               result.use_palette = 1'b1;
               cursor_x_in        = cursor_x_ff + COORD_BITS'(pending_ff);
               pending_in         = '0;
               phase_in           = PH_COUNT;
            end
            PH_ESC: begin
               if (stream_byte == 8'd0) begin
                  // End of line: back to column 0 one row up the image.
                  cursor_x_in  = '0;
                  cursor_y_in  = cursor_y_ff - COORD_BITS'(1);
                  phase_in     = PH_COUNT;
                  result.valid = 1'b1;
                  result.kind  = rle8_pkg::KIND_MOVE;
               end else if (stream_byte == 8'd1) begin
                  phase_in     = PH_END;
                  result.valid = 1'b1;
                  result.kind  = rle8_pkg::KIND_END;
               end else if (stream_byte == 8'd2) begin
                  phase_in = PH_DX;
               end else begin
                  pending_in = stream_byte;
                  pad_in     = stream_byte[0];
                  phase_in   = PH_LIT;
               end
            end
            PH_DX: begin
               cursor_x_in = cursor_x_ff + COORD_BITS'(stream_byte);
               phase_in    = PH_DY;
            end
            PH_DY: begin
               cursor_y_in  = cursor_y_ff - COORD_BITS'(stream_byte);
               phase_in     = PH_COUNT;
               result.valid = 1'b1;
               result.kind  = rle8_pkg::KIND_MOVE;
            end
            PH_LIT: begin
               result.valid       = 1'b1;
               result.kind        = rle8_pkg::KIND_PIXELS;
               result.run_count   = 8'd1;
               result.use_palette = 1'b1;
               cursor_x_in        = cursor_x_ff + COORD_BITS'(1);
               pending_in         = pending_dec;
               if (pending_dec == 8'd0) begin
                  phase_in = pad_ff ? PH_PAD : PH_COUNT;
               end
            end
            PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = PH_COUNT;
            end
            PH_END: begin
               phase_in = PH_END;
            end
         endcase
      end

      // Cursor moves report where the cursor lands; runs report their first pixel.
      sel_x = (result.kind == rle8_pkg::KIND_MOVE) ? cursor_x_in : cursor_x_ff;
      sel_y = (result.kind == rle8_pkg::KIND_MOVE) ? cursor_y_in : cursor_y_ff;
      sum_x = SUM_W'(sel_x) + SUM_W'(origin_x);
      sum_y = SUM_W'(sel_y) + SUM_W'(origin_y);
      result.pos_x = sum_x[10:0];
      result.pos_y = sum_y[10:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         cursor_x_ff <= '0;
         cursor_y_ff <= RESET_Y[COORD_BITS-1:0];
         pending_ff  <= '0;
         pad_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         pending_ff  <= pending_in;
         pad_ff      <= pad_in;
      end
   end

endmodule

/* sv/rle8_bitmap_decoder.sv */
// Top level of the 8-bit run-length bitmap decoder. A result caused by a stream
// byte is held in stage one while its registered palette read completes, and
// then in the output register until its transfer. One input transfer is
// taken every cycle while the output side keeps up. Synchronous active-high
// reset clears the parser, the pipeline valids and the configuration registers;
// the palette memory is not cleared and must be loaded before use.
module rle8_bitmap_decoder #(
   parameter int COORD_BITS    = 10,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_colour,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [10:0] rsp_pos_x,
   output logic [10:0] rsp_pos_y,
   output logic [7:0]  rsp_run_count,
   output logic [15:0] rsp_colour,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   // Configuration registers. Writes are always taken; index 3 is ignored.
   logic [10:0] frame_height_ff;
   logic [9:0]  origin_x_ff;
   logic [9:0]  origin_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= 11'(rle8_pkg::FRAME_HEIGHT_RESET);
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rle8_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            rle8_pkg::CSR_ORIGIN_X:     origin_x_ff     <= csr_wdata[9:0];
            rle8_pkg::CSR_ORIGIN_Y:     origin_y_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Pipeline control. Stage one holds a decoded result while its palette read
   // completes; the output register holds a finished result until the transfer.
   // Stage one drains whenever the output register is empty or being emptied,
   // so an input transfer is refused only when both stages are full and stalled.
   logic                 req_accept;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_move;
   rle8_pkg::result_type dec_result;
   rle8_pkg::result_type s1_ff;
   logic [15:0]          pal_rd_data;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff;
   logic [10:0]          rsp_pos_x_ff, rsp_pos_y_ff;
   logic [7:0]           rsp_run_count_ff;
   logic [15:0]          rsp_colour_ff;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   rle8_fsm #(
      .COORD_BITS(COORD_BITS)
   ) u_fsm (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .operation    (req_operation),
      .stream_byte  (req_stream_byte),
      .frame_height (frame_height_ff),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .result       (dec_result)
   );

   // The read address is the stream byte itself; its data lines up with stage one.
   rle8_palette #(
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (req_accept && req_operation == rle8_pkg::OP_PALETTE),
      .wr_addr (req_palette_index[PAL_AW-1:0]),
      .wr_data (req_palette_colour),
      .rd_en   (req_accept && req_operation == rle8_pkg::OP_STREAM),
      .rd_addr (req_stream_byte[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = dec_result.valid;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= dec_result;
      end
   end

   // Cursor moves and the end marker carry a zero colour.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_kind_ff      <= s1_ff.kind;
         rsp_pos_x_ff     <= s1_ff.pos_x;
         rsp_pos_y_ff     <= s1_ff.pos_y;
         rsp_run_count_ff <= s1_ff.run_count;
         rsp_colour_ff    <= s1_ff.use_palette ? pal_rd_data : 16'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;
   assign rsp_run_count = rsp_run_count_ff;
   assign rsp_colour    = rsp_colour_ff;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the 8-bit run-length bitmap decoder (rle8_bitmap_decoder).
// Depends on rle8_pkg for operation codes, result kinds and register indexes; a small
// scoreboard class predicts every decoded run, and plain tasks drive the request and register channels.
module tb_top;

   localparam int COORD_BITS    = 10;
   localparam int PALETTE_DEPTH = 256;

   // Operation code 3 is not defined by the block and must be ignored by it.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // Second byte of an escape sequence; larger values start a literal group.
   localparam logic [7:0] ESC_END_LINE   = 8'd0;
   localparam logic [7:0] ESC_END_BITMAP = 8'd1;
   localparam logic [7:0] ESC_DELTA      = 8'd2;

   localparam int PHASE_ITEMS = 200;
   localparam int NUM_PHASES  = 7;
   localparam int DRAIN_SLACK = 4;
   localparam int CYCLE_LIMIT = 400000;

   // Parser position inside the compressed stream.
   typedef enum logic [2:0] {
      DEC_COUNT,
      DEC_ESCAPE,
      DEC_COLOUR,
      DEC_DX,
      DEC_DY,
      DEC_LITERAL,
      DEC_PAD,
      DEC_ENDED
   } decode_phase_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  stream_byte;
      logic [7:0]  palette_index;
      logic [15:0] palette_colour;
   } stream_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic [7:0]  run_count;
      logic [15:0] colour;
   } decoded_run_type;

   // The scoreboard keeps its own copy of the parser, the cursor, the palette and the
   // registers. Every accepted input transfer is decoded here, and any run, cursor move
   // or end marker it produces is queued until the matching output transfer arrives.
   class run_scoreboard;
      logic [10:0]           frame_height;
      logic [9:0]            origin_x;
      logic [9:0]            origin_y;
      decode_phase_type      phase;
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic [7:0]            pending;
      logic                  pad;
      logic [15:0]           palette [PALETTE_DEPTH];
      decoded_run_type       expected_runs [$];
      int                    errors;

      function void restart_frame();
         logic [10:0] row;
         row      = frame_height - 11'd1;
         phase    = DEC_COUNT;
         cursor_x = '0;
         cursor_y = row[COORD_BITS-1:0];
         pending  = 8'd0;
         pad      = 1'b0;
      endfunction

      function void apply_reset();
         frame_height = 11'(rle8_pkg::FRAME_HEIGHT_RESET);
         origin_x     = 10'd0;
         origin_y     = 10'd0;
         errors       = 0;
         expected_runs.delete();
         restart_frame();
      endfunction

      function void write_register(logic [1:0] index, logic [10:0] value);
         case (index)
            rle8_pkg::CSR_FRAME_HEIGHT: frame_height = value;
            rle8_pkg::CSR_ORIGIN_X:     origin_x     = value[9:0];
            rle8_pkg::CSR_ORIGIN_Y:     origin_y     = value[9:0];
            default: ;
         endcase
      endfunction

      function void post_run(logic [1:0] kind, logic [7:0] count, logic [15:0] colour);
         decoded_run_type r;
         r.kind      = kind;
         r.pos_x     = {1'b0, cursor_x} + {1'b0, origin_x};
         r.pos_y     = {1'b0, cursor_y} + {1'b0, origin_y};
         r.run_count = count;
         r.colour    = colour;
         expected_runs.push_back(r);
      endfunction

      function void note_transfer(stream_item_type it);
         logic [7:0] b;
         b = it.stream_byte;
         if (it.operation == rle8_pkg::OP_PALETTE) begin
            palette[it.palette_index] = it.palette_colour;
            return;
         end
         if (it.operation == rle8_pkg::OP_FRAME) begin
            restart_frame();
            return;
         end
         if (it.operation != rle8_pkg::OP_STREAM) return;

         case (phase)
            DEC_COUNT: begin
               if (b == 8'd0) begin
                  phase = DEC_ESCAPE;
               end else begin
                  pending = b;
                  phase   = DEC_COLOUR;
               end
            end
            DEC_COLOUR: begin
               post_run(rle8_pkg::KIND_PIXELS, pending, palette[b]);
               cursor_x = cursor_x + {2'b00, pending};
               pending  = 8'd0;
               phase    = DEC_COUNT;
            end
            DEC_ESCAPE: begin
               case (b)
                  ESC_END_LINE: begin
                     cursor_x = '0;
                     cursor_y = cursor_y - COORD_BITS'(1);
                     phase    = DEC_COUNT;
                     post_run(rle8_pkg::KIND_MOVE, 8'd0, 16'd0);
                  end
                  ESC_END_BITMAP: begin
                     phase = DEC_ENDED;
                     post_run(rle8_pkg::KIND_END, 8'd0, 16'd0);
                  end
                  ESC_DELTA: phase = DEC_DX;
                  default: begin
                     pending = b;
                     pad     = b[0];
                     phase   = DEC_LITERAL;
                  end
               endcase
            end
            DEC_DX: begin
               cursor_x = cursor_x + {2'b00, b};
               phase    = DEC_DY;
            end
            DEC_DY: begin
               cursor_y = cursor_y - {2'b00, b};
               phase    = DEC_COUNT;
               post_run(rle8_pkg::KIND_MOVE, 8'd0, 16'd0);
            end
            DEC_LITERAL: begin
               post_run(rle8_pkg::KIND_PIXELS, 8'd1, palette[b]);
               cursor_x = cursor_x + COORD_BITS'(1);
               pending  = pending - 8'd1;
               if (pending == 8'd0) phase = pad ? DEC_PAD : DEC_COUNT;
            end
            DEC_PAD: begin
               pad   = 1'b0;
               phase = DEC_COUNT;
            end
            default: ;
         endcase
      endfunction

      function void check_run(decoded_run_type got);
         decoded_run_type want;
         if (expected_runs.size() == 0) begin
            $error("result with nothing expected: kind %0d at (%0d,%0d)",
                   got.kind, got.pos_x, got.pos_y);
            errors++;
            return;
         end
         want = expected_runs.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            errors++;
         end
         if (got.run_count !== want.run_count) begin
            $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
            errors++;
         end
         if (got.colour !== want.colour) begin
            $error("colour: expected %h, got %h", want.colour, got.colour);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_runs.size();
      endfunction
   endclass

   // Every input of the block holds a known value from time zero on.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = rle8_pkg::OP_STREAM;
   logic [7:0]  req_stream_byte = 8'd0;
   logic [7:0]  req_palette_index = 8'd0;
   logic [15:0] req_palette_colour = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [10:0] rsp_pos_x;
   logic [10:0] rsp_pos_y;
   logic [7:0]  rsp_run_count;
   logic [15:0] rsp_colour;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = rle8_pkg::CSR_FRAME_HEIGHT;
   logic [10:0] csr_wdata = 11'd0;

   run_scoreboard sb;

   // Palette entries that have been loaded. Colour bytes are drawn only from this set,
   // so the decoder never looks up an entry whose contents are undefined.
   bit          loaded [PALETTE_DEPTH];
   int unsigned loaded_list [$];

   int cycle_count = 0;

   rle8_bitmap_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_stream_byte    (req_stream_byte),
      .req_palette_index  (req_palette_index),
      .req_palette_colour (req_palette_colour),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_run_count      (rsp_run_count),
      .rsp_colour         (rsp_colour),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog. The slowest legal run is far below this count, so reaching it means the
   // block has stopped taking transfers or stopped returning results.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver switches between three stall behaviors at random: no stall at all,
   // a random stall on about a third of the cycles, or long alternating stretches of
   // stall and release. Long stalls also push back through the block onto req_stall.
   int  stall_mode = 0;
   int  mode_left  = 0;
   int  run_left   = 0;
   bit  stall_on   = 1'b0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: begin
            if (run_left == 0) begin
               stall_on = !stall_on;
               run_left = stall_on ? $urandom_range(1, 20) : $urandom_range(1, 10);
            end else begin
               run_left--;
            end
            rsp_stall <= stall_on;
         end
      endcase
   end

   // Output monitor. Values read right after the edge are the ones that were present at
   // the edge, since both the block and the drivers update through nonblocking writes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_run({rsp_kind, rsp_pos_x, rsp_pos_y, rsp_run_count, rsp_colour});
   end

   function automatic stream_item_type make_item(logic [1:0] op, logic [7:0] b,
                                                 logic [7:0] index, logic [15:0] colour);
      stream_item_type it;
      it.operation      = op;
      it.stream_byte    = b;
      it.palette_index  = index;
      it.palette_colour = colour;
      return it;
   endfunction

   function automatic void mark_loaded(logic [7:0] index);
      if (!loaded[index]) begin
         loaded[index] = 1'b1;
         loaded_list.push_back(32'(index));
      end
   endfunction

   // Picks the next stream byte from the parser position, so that most of the stream
   // forms valid commands with random content, with some plain noise mixed in.
   function automatic logic [7:0] pick_stream_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (sb.phase)
         DEC_COLOUR, DEC_LITERAL:
            return 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
         DEC_COUNT: begin
            if (roll < 5)  return 8'($urandom);
            if (roll < 40) return 8'd0;
            if (roll < 75) return 8'($urandom_range(1, 8));
            return 8'($urandom_range(1, 255));
         end
         DEC_ESCAPE: begin
            if (roll < 5)  return 8'($urandom);
            if (roll < 30) return ESC_END_LINE;
            if (roll < 35) return ESC_END_BITMAP;
            if (roll < 55) return ESC_DELTA;
            if (roll < 88) return 8'($urandom_range(3, 10));
            if (roll < 97) return 8'($urandom_range(11, 64));
            return 8'($urandom_range(65, 255));
         end
         default: return 8'($urandom);
      endcase
   endfunction

   // Palette writes and frame starts are mixed into the stream, and a frame start may
   // cut a command short. After the end of a bitmap a new frame usually follows soon.
   function automatic stream_item_type next_item();
      stream_item_type it;
      int unsigned     roll;
      it   = make_item(rle8_pkg::OP_STREAM, 8'($urandom), 8'($urandom), 16'($urandom));
      roll = $urandom_range(0, 99);
      if (sb.phase == DEC_ENDED && roll < 60) it.operation = rle8_pkg::OP_FRAME;
      else if (roll < 6) it.operation = rle8_pkg::OP_PALETTE;
      else if (roll < 8) it.operation = rle8_pkg::OP_FRAME;
      else if (roll < 9) it.operation = OP_IGNORED;
      else it.stream_byte = pick_stream_byte();
      if (it.operation == rle8_pkg::OP_PALETTE) mark_loaded(it.palette_index);
      return it;
   endfunction

   // Presents one item and holds it until the block takes the transfer.
   task automatic send_item(input stream_item_type it);
      req_valid          <= 1'b1;
      req_operation      <= it.operation;
      req_stream_byte    <= it.stream_byte;
      req_palette_index  <= it.palette_index;
      req_palette_colour <= it.palette_colour;
      do @(posedge clock); while (req_stall);
      sb.note_transfer(it);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Idles the sender until every expected result has come out, then idles on so that
   // items that cause no result have also left the pipeline.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Writes all three registers back to back. Only called while the block is idle.
   task automatic write_config(input logic [10:0] height, input logic [10:0] org_x,
                               input logic [10:0] org_y);
      logic [1:0]  indexes [3];
      logic [10:0] values  [3];
      indexes = '{rle8_pkg::CSR_FRAME_HEIGHT, rle8_pkg::CSR_ORIGIN_X,
                  rle8_pkg::CSR_ORIGIN_Y};
      values  = '{height, org_x, org_y};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_register(indexes[i], values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      stream_item_type directed [$];
      stream_item_type it;
      logic [10:0]     height;
      logic [10:0]     org_x;
      logic [10:0] org_y;
      int              counted;
      int              burst_left;
      int              gap;
      bit              mid_drained;
      bit              ignored;

      sb = new;
      sb.apply_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset configuration: palette extremes, the longest run,
      // a one-pixel run, an odd literal group with its pad byte, line end, the largest
      // delta, the undefined operation, end of bitmap and a byte after it.
      directed.push_back(make_item(rle8_pkg::OP_PALETTE, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_PALETTE, 8'h00, 8'hFF, 16'hFFFF));
      directed.push_back(make_item(rle8_pkg::OP_PALETTE, 8'h00, 8'h5A, 16'hA5C3));
      directed.push_back(make_item(rle8_pkg::OP_FRAME, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'hFF, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'hFF, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h01, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h03, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'hFF, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h5A, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h77, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, ESC_END_LINE, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, ESC_DELTA, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'hFF, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'hFF, 8'h00, 16'h0000));
      directed.push_back(make_item(OP_IGNORED, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, ESC_END_BITMAP, 8'h00, 16'h0000));
      directed.push_back(make_item(rle8_pkg::OP_STREAM, 8'h00, 8'h00, 16'h0000));
      mark_loaded(8'h00);
      mark_loaded(8'hFF);
      mark_loaded(8'h5A);
      foreach (directed[i]) send_item(directed[i]);
      wait_drained();

      // Random part, one configuration per phase. The first phases take the extremes,
      // including the out-of-range heights 0 and 2047 that wrap the bottom row.
      for (int phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
         case (phase_no)
            0: begin height = 11'd1;    org_x = 11'd0;    org_y = 11'd0;    end
            1: begin height = 11'd1024; org_x = 11'd1023; org_y = 11'd1023; end
            2: begin height = 11'd0;    org_x = 11'd512;  org_y = 11'd1;    end
            3: begin
               height = 11'd2047;
               org_x  = 11'($urandom_range(0, 1023));
               org_y  = 11'($urandom_range(0, 1023));
            end
            default: begin
               height = 11'($urandom_range(1, 1024));
               org_x  = 11'($urandom_range(0, 1023));
               org_y  = 11'($urandom_range(0, 1023));
            end
         endcase
         write_config(height, org_x, org_y);

         // Usually restart the frame so the new height takes effect; sometimes keep
         // decoding with the old cursor, since the height is read only at frame start.
         if ($urandom_range(0, 99) < 70)
            send_item(make_item(rle8_pkg::OP_FRAME, 8'($urandom), 8'($urandom),
                                16'($urandom)));

         counted     = 0;
         mid_drained = 1'b0;
         burst_left  = $urandom_range(1, 30);
         while (counted < PHASE_ITEMS) begin
            it      = next_item();
            ignored = (it.operation == OP_IGNORED) ||
                      (it.operation == rle8_pkg::OP_STREAM && sb.phase == DEC_ENDED);
            if (!ignored) counted++;
            send_item(it);

            // Halfway through each phase the sender holds off until the output is empty.
            if (!mid_drained && counted >= PHASE_ITEMS / 2) begin
               mid_drained = 1'b1;
               wait_drained();
            end

            burst_left--;
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) pause_sender(gap);
               burst_left = $urandom_range(1, 30);
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
